[design/dls_pkg.sv]
`timescale 1ns / 1ps
// Package for the performance level selector: widths, action codes,
// frequency and transition tables, result and state structs. No dependencies.
package dls_pkg;

   localparam int LEVEL_W = 3;
   localparam int FREQ_W  = 20;
   localparam int HOLD_W  = 16;
   localparam int NUM_LEVELS = 5;

   // action codes
   localparam logic [2:0] ACT_STEP    = 3'd0;
   localparam logic [2:0] ACT_LOOKUP  = 3'd1;
   localparam logic [2:0] ACT_BOOST   = 3'd2;
   localparam logic [2:0] ACT_HOLD    = 3'd3;
   localparam logic [2:0] ACT_RELEASE = 3'd4;

   // direction codes; anything at or above DIR_INVALID is an error
   localparam logic [1:0] DIR_DOWN    = 2'd0;
   localparam logic [1:0] DIR_UP      = 2'd1;
   localparam logic [1:0] DIR_INVALID = 2'd2;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL_SHORT = 3'd3;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL_LONG  = 3'd4;

   localparam logic signed [HOLD_W-1:0] HOLD_MAX = 16'sh7FFF;
   localparam logic signed [HOLD_W-1:0] HOLD_MIN = -16'sh8000;

   // [table][level], descending frequency in kHz
   localparam logic [FREQ_W-1:0] LEVEL_FREQ [2][NUM_LEVELS] = '{
      '{20'd532000, 20'd266000, 20'd133000, 20'd66000, 20'd66000},
      '{20'd800000, 20'd400000, 20'd266000, 20'd133000, 20'd66000}
   };

   // [table][level][0 down, 1 up]
   localparam logic [LEVEL_W-1:0] TRANS_TAB [2][NUM_LEVELS][2] = '{
      '{'{3'd1, 3'd0}, '{3'd2, 3'd0}, '{3'd3, 3'd1}, '{3'd3, 3'd2}, '{3'd3, 3'd2}},
      '{'{3'd1, 3'd0}, '{3'd2, 3'd0}, '{3'd3, 3'd1}, '{3'd4, 3'd2}, '{3'd4, 3'd3}}
   };

   typedef struct packed {
      logic [LEVEL_W-1:0]        level;
      logic [LEVEL_W-1:0]        cap;
      logic signed [HOLD_W-1:0]  hold;
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [FREQ_W-1:0]  level_freq;
      logic               direction_error;
   } result_type;

   function automatic logic [LEVEL_W-1:0] max_level(input logic table_sel);
      return table_sel ? MAX_LEVEL_LONG : MAX_LEVEL_SHORT;
   endfunction

   // clamp a level to the slowest level of the table
   function automatic logic [LEVEL_W-1:0] safe_level(input logic [LEVEL_W-1:0] lv,
                                                      input logic table_sel);
      logic [LEVEL_W-1:0] m;
      m = max_level(table_sel);
      return (lv > m) ? m : lv;
   endfunction

endpackage

[design/dls_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
// Depends on dls_pkg for field widths.
interface dls_req_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    action;
   logic [dls_pkg::FREQ_W-1:0]    request_freq;
   logic [1:0]                    direction;

   modport source (output valid, output action, output request_freq, output direction,
                   input ready);
   modport sink   (input valid, input action, input request_freq, input direction,
                   output ready);
endinterface

interface dls_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dls_pkg::LEVEL_W-1:0]   level;
   logic [dls_pkg::FREQ_W-1:0]    level_freq;
   logic                          direction_error;

   modport source (output valid, output level, output level_freq, output direction_error,
                   input ready);
   modport sink   (input valid, input level, input level_freq, input direction_error,
                   output ready);
endinterface

[design/dls_level_calc.sv]
`timescale 1ns / 1ps
// Next-state and result logic for one request beat.
// Depends on dls_pkg.
module dls_level_calc (
   input  logic                          table_sel,
   input  dls_pkg::state_type            state,
   input  logic [2:0]                    action,
   input  logic [dls_pkg::FREQ_W-1:0]    request_freq,
   input  logic [1:0]                    direction,
   output dls_pkg::state_type            state_next,
   output dls_pkg::result_type           result
);

   logic [dls_pkg::LEVEL_W-1:0] cur;
   logic [dls_pkg::LEVEL_W-1:0] maxl;
   logic [dls_pkg::FREQ_W-1:0]  top_freq;
   logic [dls_pkg::FREQ_W-1:0]  cur_freq;
   logic                        cur_match;
   logic [dls_pkg::NUM_LEVELS-1:0] at_or_above;
   logic [dls_pkg::LEVEL_W-1:0] ge_count;
   logic [dls_pkg::LEVEL_W-1:0] step_raw;
   logic [dls_pkg::LEVEL_W-1:0] look_raw;
   logic [dls_pkg::LEVEL_W-1:0] out_level;
   logic                        dir_err;

   assign cur       = dls_pkg::safe_level(state.level, table_sel);
   assign maxl      = dls_pkg::max_level(table_sel);
   assign top_freq  = dls_pkg::LEVEL_FREQ[table_sel][0];
   assign cur_freq  = dls_pkg::LEVEL_FREQ[table_sel][cur];
   assign cur_match = (cur_freq == request_freq);

   // lookup: slowest level whose frequency still meets the request
   always_comb begin
      for (int j = 0; j < dls_pkg::NUM_LEVELS; j++) begin
         at_or_above[j] = (dls_pkg::LEVEL_W'(j) <= maxl) &&
                          (dls_pkg::LEVEL_FREQ[table_sel][j] >= request_freq);
      end
   end

   assign ge_count = dls_pkg::LEVEL_W'($countones(at_or_above));
   assign look_raw = ge_count - 3'd1;

   // step: ride the transition table on a match, else jump near the top
   always_comb begin
      if (request_freq > top_freq) begin
         step_raw = '0;
      end else if (cur_match) begin
         step_raw = dls_pkg::TRANS_TAB[table_sel][cur][direction == dls_pkg::DIR_UP];
      end else if (direction == dls_pkg::DIR_DOWN) begin
         step_raw = 3'd1;
      end else begin
         step_raw = '0;
      end
   end

   always_comb begin
      state_next = state;
      dir_err    = 1'b0;
      unique case (action)
         dls_pkg::ACT_STEP: begin
            dir_err = (request_freq <= top_freq) && (direction >= dls_pkg::DIR_INVALID);
            state_next.level = dls_pkg::safe_level(
               (step_raw > state.cap) ? state.cap : step_raw, table_sel);
         end
         dls_pkg::ACT_LOOKUP: begin
            if (request_freq >= top_freq) begin
               state_next.level = '0;
            end else if (cur_match) begin
               state_next.level = cur;
            end else begin
               state_next.level = dls_pkg::safe_level(
                  (look_raw > state.cap) ? state.cap : look_raw, table_sel);
            end
         end
         dls_pkg::ACT_BOOST: begin
            state_next.level = '0;
         end
         dls_pkg::ACT_HOLD: begin
            if (state.hold > 0) begin
               if (state.hold != dls_pkg::HOLD_MAX) state_next.hold = state.hold + 16'sd1;
            end else begin
               state_next.cap  = maxl - 3'd1;
               state_next.hold = state.hold + 16'sd1;
            end
         end
         dls_pkg::ACT_RELEASE: begin
            if (state.hold > 1) begin
               state_next.hold = state.hold - 16'sd1;
            end else begin
               state_next.cap = maxl;
               if (state.hold != dls_pkg::HOLD_MIN) state_next.hold = state.hold - 16'sd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign out_level              = dls_pkg::safe_level(state_next.level, table_sel);
   assign result.level           = out_level;
   assign result.level_freq      = dls_pkg::LEVEL_FREQ[table_sel][out_level];
   assign result.direction_error = dir_err;

endmodule

[design/dls_out_queue.sv]
`timescale 1ns / 1ps
// Two-entry response buffer: output register plus skid register.
// Depends on dls_pkg.
module dls_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dls_pkg::result_type  push_data,
   output logic                 can_push,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dls_pkg::result_type  out_data
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   dls_pkg::result_type main_ff, main_in;
   dls_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop       = main_valid_ff && out_ready;
   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

[design/dvfs_level_selector.sv]
`timescale 1ns / 1ps
// Performance level selector, top level; responses are registered. Throughput:
// one beat per cycle while the skid register is empty; the level/cap/hold update
// is a single pass through the table compares. A 2-deep response buffer lets
// requests keep flowing while one response is stalled. Synchronous active-high
// reset: level 0, cap 3, hold count 0, four-level table, response buffer empty.
module dvfs_level_selector (
   input  logic            clock,
   input  logic            reset,
   dls_req_if.sink         req_bus,
   dls_rsp_if.source       rsp_bus,
   input  logic            csr_write_en,
   input  logic            csr_write_data
);

   // table_sel 0: 532 MHz / four levels, 1: 800 MHz / five levels
   logic                table_sel_ff, table_sel_in;
   dls_pkg::state_type  state_ff, state_in;
   dls_pkg::state_type  state_next;
   dls_pkg::result_type result;
   dls_pkg::result_type out_data;
   logic                req_fire;
   logic                can_push;

   assign req_bus.ready = can_push;
   assign req_fire      = req_bus.valid && can_push;

   dls_level_calc u_calc (
      .table_sel    (table_sel_ff),
      .state        (state_ff),
      .action       (req_bus.action),
      .request_freq (req_bus.request_freq),
      .direction    (req_bus.direction),
      .state_next   (state_next),
      .result       (result)
   );

   // The user must write the CSR only while idle; the block does not enforce this.
   // A table switch reloads the cap and clips the level into the new table.
   always_comb begin
      table_sel_in = table_sel_ff;
      state_in     = state_ff;
      if (csr_write_en) begin
         table_sel_in   = csr_write_data;
         state_in.cap   = dls_pkg::max_level(csr_write_data);
         state_in.level = dls_pkg::safe_level(state_ff.level, csr_write_data);
      end else if (req_fire) begin
         state_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_sel_ff   <= 1'b0;
         state_ff.level <= '0;
         state_ff.cap   <= dls_pkg::MAX_LEVEL_SHORT;
         state_ff.hold  <= '0;
      end else begin
         table_sel_ff <= table_sel_in;
         state_ff     <= state_in;
      end
   end

   dls_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (result),
      .can_push  (can_push),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (out_data)
   );

   assign rsp_bus.level           = out_data.level;
   assign rsp_bus.level_freq      = out_data.level_freq;
   assign rsp_bus.direction_error = out_data.direction_error;

   // level stays inside the active table
   a_level_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff.level <= dls_pkg::max_level(table_sel_ff))
      else $error("level beyond slowest table entry");

   // cap is either the slowest level or one above it
   a_cap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.cap == dls_pkg::max_level(table_sel_ff)) ||
      (state_ff.cap == dls_pkg::max_level(table_sel_ff) - 3'd1))
      else $error("level cap out of range");

   // after every accepted request beat, a response is valid the next cycle
   a_beat_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> rsp_bus.valid)
      else $error("accepted beat produced no response");

endmodule
